[sv/ecu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecu_pkg
// Shared types and constants of the epsilon closure unit.
// ----------------------------------------------------------------------------
package ecu_pkg;

    localparam int MASK_W  = 32;
    localparam int IDX_W   = 5;
    localparam int EXT_W   = 64;
    localparam int IDXX_W  = 7;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_MERGE
    } t_fsm;

endpackage : ecu_pkg
`default_nettype wire

[sv/ecu_row_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecu_row_store
// Epsilon row memory with one write port, one registered read port and
// per-row valid bits so that unwritten rows read as zero after reset.
// ----------------------------------------------------------------------------
module ecu_row_store
    import ecu_pkg::*;
#(
    parameter int STATES = 32,
    parameter int SW     = (STATES > 1) ? $clog2(STATES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [SW-1:0]     i_wr_addr,
    input  wire logic [STATES-1:0] i_wr_row,
    input  wire logic [SW-1:0]     i_rd_addr,
    output logic      [STATES-1:0] o_rd_row
);

    logic [STATES-1:0] r_mem [STATES];
    logic [STATES-1:0] r_valid;
    logic [STATES-1:0] r_rd_row;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        r_rd_row <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_vld ? r_rd_row : '0;

endmodule : ecu_row_store
`default_nettype wire

[sv/epsilon_closure_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsilon_closure_unit
// Epsilon closure of a seed state set over a stored epsilon adjacency.
// ----------------------------------------------------------------------------
// A load transfer writes one epsilon row, gives no result and leaves busy
// low. A query transfer raises busy while a worklist walks the closure: in
// S_PICK it picks the lowest reached state not yet expanded and reads its
// row from the single read port of the row memory, and in S_MERGE it ORs
// the row in. The result is on o_closure_mask for the one cycle that
// o_strobe is high and cannot be held off. Rows are zero after reset
// without any clearing pass.
// ----------------------------------------------------------------------------
module epsilon_closure_unit
    import ecu_pkg::*;
#(
    parameter int STATES = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_func,
    input  wire logic [IDX_W-1:0]  i_state_index,
    input  wire logic [MASK_W-1:0] i_state_mask,
    output logic                   o_strobe,
    output logic      [MASK_W-1:0] o_closure_mask
);

    localparam int SW = (STATES > 1) ? $clog2(STATES) : 1;

    t_fsm              r_state, n_state;
    logic [STATES-1:0] r_set, n_set;
    logic [STATES-1:0] r_done, n_done;
    logic              r_strobe, n_strobe;
    logic [MASK_W-1:0] r_closure, n_closure;

    logic              w_accept;
    logic [EXT_W-1:0]  w_mask_ext;
    logic [STATES-1:0] w_mask_row;
    logic [IDXX_W-1:0] w_idx_ext;
    logic              w_wr_en;
    logic [STATES-1:0] w_pend;
    logic [STATES-1:0] w_onehot;
    logic [SW-1:0]     w_pick;
    logic [STATES-1:0] w_rd_row;
    logic [EXT_W-1:0]  w_set_ext;

    assign w_accept   = start && !busy;
    assign w_mask_ext = EXT_W'(i_state_mask);
    assign w_mask_row = w_mask_ext[STATES-1:0];
    assign w_idx_ext  = IDXX_W'(i_state_index);
    assign w_wr_en    = w_accept && (i_func == FUNC_LOAD) && (w_idx_ext < IDXX_W'(STATES));

    assign w_pend   = r_set & ~r_done;
    assign w_onehot = w_pend & (~w_pend + STATES'(1));

    always_comb begin
        w_pick = '0;
        for (int i = 0; i < STATES; i++) begin
            if (w_onehot[i]) begin
                w_pick = w_pick | SW'(i);
            end
        end
    end

    assign w_set_ext = EXT_W'(r_set);

    ecu_row_store #(
        .STATES (STATES),
        .SW     (SW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_idx_ext[SW-1:0]),
        .i_wr_row  (w_mask_row),
        .i_rd_addr (w_pick),
        .o_rd_row  (w_rd_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set     <= n_set;
        r_done    <= n_done;
        r_closure <= n_closure;
    end

    always_comb begin
        n_state   = r_state;
        n_set     = r_set;
        n_done    = r_done;
        n_strobe  = 1'b0;
        n_closure = r_closure;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_func == FUNC_QUERY)) begin
                    n_set   = w_mask_row;
                    n_done  = '0;
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (w_pend == '0) begin
                    n_strobe  = 1'b1;
                    n_closure = w_set_ext[MASK_W-1:0];
                    n_state   = S_IDLE;
                end else begin
                    n_done  = r_done | w_onehot;
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                n_set   = r_set | w_rd_row;
                n_state = S_PICK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_closure_mask = r_closure;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while a query is still running");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_QUERY) |=> busy)
        else $error("query transfer did not start the walk");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_LOAD) |=> (!o_strobe && !busy))
        else $error("load transfer produced a result or raised busy");

    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> ((r_done & ~r_set) == '0))
        else $error("expanded a state outside the reached set");

endmodule : epsilon_closure_unit
`default_nettype wire

[verif/epsilon_closure_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsilon_closure_checker
// Watches the epsilon closure unit and checks every closure it returns.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the epsilon rows, updated by every
// accepted load transfer. For every accepted query it computes the closure
// of the seed by growing the set until no new state appears and queues it.
// Each strobed result is compared with the oldest queued closure. The first
// ten mismatches are printed; all of them are counted.
// ----------------------------------------------------------------------------
module epsilon_closure_checker
    import ecu_pkg::*;
#(
    parameter int STATES = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic              i_func,
    input  wire logic [IDX_W-1:0]  i_state_index,
    input  wire logic [MASK_W-1:0] i_state_mask,
    input  wire logic              i_strobe,
    input  wire logic [MASK_W-1:0] i_closure_mask,
    output int                     o_mismatches,
    output int                     o_pending,
    output int                     o_compared
);

    localparam logic [EXT_W-1:0] LIVE_STATES =
        (STATES >= EXT_W) ? {EXT_W{1'b1}} : ((64'd1 << STATES) - 64'd1);

    logic [EXT_W-1:0]  eps_rows [STATES];
    logic [MASK_W-1:0] expected_closures [$];
    int                mismatch_count;
    int                compare_count;

    function automatic logic [EXT_W-1:0] reachable_states(input logic [EXT_W-1:0] seed);
        logic [EXT_W-1:0] reached;
        logic [EXT_W-1:0] grown;
        reached = seed & LIVE_STATES;
        for (int pass = 0; pass < STATES; pass++) begin
            grown = reached;
            for (int s = 0; s < STATES && s < EXT_W; s++) begin
                if (reached[s]) begin
                    grown = grown | eps_rows[s];
                end
            end
            grown = grown & LIVE_STATES;
            if (grown == reached) begin
                break;
            end
            reached = grown;
        end
        return reached;
    endfunction

    initial begin
        mismatch_count = 0;
        compare_count  = 0;
        o_mismatches   = 0;
        o_pending      = 0;
        o_compared     = 0;
        foreach (eps_rows[i]) begin
            eps_rows[i] = '0;
        end
    end

    always @(posedge i_clk) begin
        logic [MASK_W-1:0] want;
        logic [EXT_W-1:0]  closure;
        if (!i_rst_n) begin
            foreach (eps_rows[i]) begin
                eps_rows[i] = '0;
            end
            expected_closures.delete();
        end else begin
            if (i_strobe) begin
                if (expected_closures.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("Mismatch: unexpected closure %h, none pending",
                                 i_closure_mask);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_closures.pop_front();
                    compare_count++;
                    if (i_closure_mask !== want) begin
                        if (mismatch_count < 10) begin
                            $display("Mismatch: closure_mask expected %h, actual %h",
                                     want, i_closure_mask);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_func == FUNC_LOAD) begin
                    if (int'(i_state_index) < STATES) begin
                        eps_rows[i_state_index] = EXT_W'(i_state_mask) & LIVE_STATES;
                    end
                end else begin
                    closure = reachable_states(EXT_W'(i_state_mask));
                    expected_closures = {expected_closures, closure[MASK_W-1:0]};
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_closures.size();
        o_compared   <= compare_count;
    end

endmodule : epsilon_closure_checker

[verif/epsilon_closure_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsilon_closure_unit_test
// Testbench top of the epsilon closure unit.
// ----------------------------------------------------------------------------
// Drives row loads and closure queries in bursts separated by random idle
// gaps. A short directed part covers empty and full seeds, self edges,
// cycles and a row with every target. The random part mixes sparse row
// loads, queries, full-length chain builds and clearing passes. All checking
// is done by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module epsilon_closure_unit_test;
    import ecu_pkg::*;

    localparam int STATES       = 32;
    localparam int TARGET_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 2 * STATES + 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_func;
    logic [IDX_W-1:0]  i_state_index;
    logic [MASK_W-1:0] i_state_mask;
    logic              o_strobe;
    logic [MASK_W-1:0] o_closure_mask;

    int mismatches;
    int pending;
    int compared;
    int n_loads;
    int n_queries;
    int burst_left;
    int cycles;

    epsilon_closure_unit #(
        .STATES(STATES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_state_index  (i_state_index),
        .i_state_mask   (i_state_mask),
        .o_strobe       (o_strobe),
        .o_closure_mask (o_closure_mask)
    );

    epsilon_closure_checker #(
        .STATES(STATES)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_func         (i_func),
        .i_state_index  (i_state_index),
        .i_state_mask   (i_state_mask),
        .i_strobe       (o_strobe),
        .i_closure_mask (o_closure_mask),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_compared     (compared)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
    end

    task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                             input logic [MASK_W-1:0] mask);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            repeat (gap) begin
                @(negedge i_clk);
                start         <= 1'b0;
                i_func        <= 1'($urandom);
                i_state_index <= IDX_W'($urandom);
                i_state_mask  <= $urandom;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        start         <= 1'b1;
        i_func        <= func;
        i_state_index <= idx;
        i_state_mask  <= mask;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (func == FUNC_LOAD) begin
            n_loads++;
        end else begin
            n_queries++;
        end
    endtask

    task automatic load_row(input logic [IDX_W-1:0] idx, input logic [MASK_W-1:0] mask);
        send_item(FUNC_LOAD, idx, mask);
    endtask

    task automatic query(input logic [MASK_W-1:0] seed);
        send_item(FUNC_QUERY, IDX_W'($urandom), seed);
    endtask

    function automatic logic [MASK_W-1:0] sparse_targets();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3, 4: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            5, 6, 7: return (MASK_W'(1) << $urandom_range(0, MASK_W - 1))
                          | (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
            8:       return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] random_seed();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            6:       return '0;
            7:       return $urandom;
            8:       return '1;
            default: return (MASK_W'(1) << $urandom_range(0, MASK_W - 1))
                          | (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
        endcase
    endfunction

    initial begin
        int pick;
        int first;
        start         = 1'b0;
        i_func        = FUNC_LOAD;
        i_state_index = '0;
        i_state_mask  = '0;
        i_rst_n       = 1'b0;
        burst_left    = 0;
        n_loads       = 0;
        n_queries     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        query('0);
        query('1);
        load_row(0, 32'h0000_0002);
        load_row(1, 32'h0000_0004);
        load_row(2, 32'h8000_0000);
        load_row(31, 32'h0000_0001);
        query(32'h0000_0001);
        query(32'h8000_0000);
        load_row(5, 32'h0000_0020);
        query(32'h0000_0020);
        query(32'h0000_0008);
        load_row(10, '1);
        query(32'h0000_0400);
        load_row(10, '0);
        query(32'h0000_0400);
        load_row(31, '0);
        query(32'h0000_0001);
        query(32'h0000_0421);
        query('1);

        while (n_loads + n_queries < TARGET_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                // A chain through every state gives the longest closure walk.
                for (int k = 0; k < STATES - 1; k++) begin
                    load_row(IDX_W'(k), MASK_W'(1) << (k + 1));
                end
                load_row(IDX_W'(STATES - 1), $urandom_range(0, 1) ? 32'h0000_0001 : '0);
                query(32'h0000_0001);
                first = $urandom_range(0, STATES - 1);
                query(MASK_W'(1) << first);
            end else if (pick < 3) begin
                for (int k = 0; k < STATES; k++) begin
                    load_row(IDX_W'(k), '0);
                end
            end else if (pick < 50) begin
                load_row(IDX_W'($urandom), sparse_targets());
            end else begin
                query(random_seed());
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d transfers: %0d row loads and %0d closure queries, %0d closures checked.",
                 n_loads + n_queries, n_loads, n_queries, compared);
        $display("Stimulus covered self edges, cycles, full rows and full-length chains.");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule : epsilon_closure_unit_test
